// ----- rtl/mbp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mbp_pkg: shared types and constants
// Store geometry, request and status codes, and controller types for the
// masked bilinear pooling engine.
// ----------------------------------------------------------------------------
package mbp_pkg;

  localparam int MaxPositions = 256;
  localparam int MaxAChannels = 64;
  localparam int MaxBChannels = 64;
  localparam int MaxFields    = 16;

  localparam int PosW  = $clog2(MaxPositions);
  localparam int AChW  = $clog2(MaxAChannels);
  localparam int BChW  = $clog2(MaxBChannels);
  localparam int FldW  = $clog2(MaxFields);
  localparam int ADepth = MaxAChannels * MaxPositions;
  localparam int BDepth = MaxBChannels * MaxPositions;
  localparam int MDepth = MaxFields * MaxPositions;
  localparam int AAddrW = $clog2(ADepth);
  localparam int BAddrW = $clog2(BDepth);
  localparam int MAddrW = $clog2(MDepth);

  localparam logic [1:0] REQ_LOAD_A = 2'd0;
  localparam logic [1:0] REQ_LOAD_B = 2'd1;
  localparam logic [1:0] REQ_LOAD_M = 2'd2;
  localparam logic [1:0] REQ_QUERY  = 2'd3;

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_QUERY = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  localparam logic [1:0] CFG_POSITIONS = 2'd0;
  localparam logic [1:0] CFG_A_CHANNELS = 2'd1;
  localparam logic [1:0] CFG_B_CHANNELS = 2'd2;
  localparam logic [1:0] CFG_FIELDS = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_RUN, S_DRAIN, S_DONE
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic       clear;    // start of query: clear accumulator
    logic [PosW-1:0] pos; // read position
    logic       feed;     // valid tag into the pipeline
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic busy;           // pipeline still holds work
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/masked_bilinear_pooling.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// masked_bilinear_pooling: one entry of the masked bilinear outer product
// Loads and rejected requests give their result in the cycle after the start
// transfer. A query walks the single multiply-accumulate one position per
// cycle over npos positions, then waits for the pipeline to drain before
// giving its result. busy stays high through the result cycle, so no new
// transfer is taken until the previous result is out; the receiver cannot
// stall.
// Reset sets the configuration and control registers to their defaults;
// stores are undefined until written, and no clearing pass is run.
// ----------------------------------------------------------------------------
module masked_bilinear_pooling (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          req_type,
  input  wire logic [5:0]          row,
  input  wire logic [7:0]          position,
  input  wire logic signed [15:0]  sample,
  input  wire logic [5:0]          a_channel,
  input  wire logic [5:0]          b_channel,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [31:0]         cfg_data,
  output logic                     result_valid,
  output logic signed [47:0]       pooled_value,
  output logic [1:0]               status,
  output logic                     saturated
);
  import mbp_pkg::*;

  // Configuration registers, stored raw and clamped where used.
  logic [8:0] positions_in_use;
  logic [6:0] a_channels_in_use, b_channels_in_use;
  logic [4:0] fields_in_use;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      positions_in_use  <= 9'd256;
      a_channels_in_use <= 7'd64;
      b_channels_in_use <= 7'd64;
      fields_in_use     <= 5'd16;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_POSITIONS:  positions_in_use  <= cfg_data[8:0];
        CFG_A_CHANNELS: a_channels_in_use <= cfg_data[6:0];
        CFG_B_CHANNELS: b_channels_in_use <= cfg_data[6:0];
        CFG_FIELDS:     fields_in_use     <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Clamp every count to the range [1, maximum].
  logic [8:0] npos;
  logic [6:0] na, nb;
  logic [4:0] nf;
  assign npos = (positions_in_use == 0) ? 9'd1 :
                (positions_in_use > 9'(MaxPositions)) ? 9'(MaxPositions) : positions_in_use;
  assign na = (a_channels_in_use == 0) ? 7'd1 :
              (a_channels_in_use > 7'(MaxAChannels)) ? 7'(MaxAChannels) : a_channels_in_use;
  assign nb = (b_channels_in_use == 0) ? 7'd1 :
              (b_channels_in_use > 7'(MaxBChannels)) ? 7'(MaxBChannels) : b_channels_in_use;
  assign nf = (fields_in_use == 0) ? 5'd1 :
              (fields_in_use > 5'(MaxFields)) ? 5'(MaxFields) : fields_in_use;

  // Decode the incoming transfer.
  logic       take;
  logic       is_query;
  logic [6:0] load_rows;
  logic       load_ok, query_ok;
  assign take     = start && !busy;
  assign is_query = (req_type == REQ_QUERY);
  always_comb begin
    case (req_type)
      REQ_LOAD_A: load_rows = na;
      REQ_LOAD_B: load_rows = nb;
      default:    load_rows = {2'b00, nf};
    endcase
  end
  assign load_ok  = ({1'b0, row} < load_rows) && ({1'b0, position} < npos);
  assign query_ok = ({1'b0, row} < {2'b00, nf}) && ({1'b0, a_channel} < na) &&
                    ({1'b0, b_channel} < nb);

  // Query operands are held for the whole walk.
  logic [5:0] q_row, q_a, q_b;
  always_ff @(posedge clk) begin
    if (take && is_query) begin
      q_row <= row;
      q_a   <= a_channel;
      q_b   <= b_channel;
    end
  end

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     q_done, q_active;
  logic signed [47:0] acc;
  logic     acc_sat;

  mbp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .go(take && is_query && query_ok), .npos(npos),
    .stat(stat), .cmd(cmd), .done(q_done), .active(q_active));

  mbp_datapath u_dp (
    .clk(clk), .rst(rst),
    .we_a(take && req_type == REQ_LOAD_A && load_ok),
    .we_b(take && req_type == REQ_LOAD_B && load_ok),
    .we_m(take && req_type == REQ_LOAD_M && load_ok),
    .ld_row(row), .ld_pos(position), .ld_sample(sample),
    .q_row(q_row), .q_a(q_a), .q_b(q_b),
    .cmd(cmd), .stat(stat), .acc(acc), .sat(acc_sat));

  // Short results (loads and rejections) come from a register.
  logic       short_valid;
  logic [1:0] short_status;
  always_ff @(posedge clk) begin
    if (rst) begin
      short_valid <= 1'b0;
    end else begin
      short_valid <= take && !(is_query && query_ok);
    end
    short_status <= (is_query ? query_ok : load_ok) ? ST_LOAD : ST_ERROR;
  end

  assign busy         = q_active || short_valid;
  assign result_valid = short_valid || q_done;
  assign pooled_value = q_done ? acc : 48'sd0;
  assign status       = q_done ? ST_QUERY : short_status;
  assign saturated    = q_done ? acc_sat : 1'b0;

  // A short result and a query result never share a cycle.
  assert property (@(posedge clk) disable iff (rst) !(short_valid && q_done))
    else $error("short and query results collide");
  // No transfer is taken while a query is running.
  assert property (@(posedge clk) disable iff (rst) q_active |-> !take)
    else $error("transfer taken during a query");
  // A query result always follows a drain of the pipeline.
  assert property (@(posedge clk) disable iff (rst) q_done |-> !stat.busy)
    else $error("query result with pipeline busy");
endmodule
`default_nettype wire

// ----- rtl/mbp_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mbp_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mbp_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/mbp_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mbp_datapath: stores and multiply-accumulate pipeline
// Holds the three stores and walks one position per cycle through a
// read, mask-multiply, product and saturating accumulate pipeline.
// ----------------------------------------------------------------------------
module mbp_datapath (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     we_a,
  input  wire logic                     we_b,
  input  wire logic                     we_m,
  input  wire logic [5:0]               ld_row,
  input  wire logic [7:0]               ld_pos,
  input  wire logic signed [15:0]       ld_sample,
  input  wire logic [5:0]               q_row,
  input  wire logic [5:0]               q_a,
  input  wire logic [5:0]               q_b,
  input  wire mbp_pkg::dp_cmd_t         cmd,
  output mbp_pkg::dp_stat_t             stat,
  output logic signed [47:0]            acc,
  output logic                          sat
);
  import mbp_pkg::*;

  localparam logic signed [47:0] AccMax = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] AccMin = {1'b1, {47{1'b0}}};

  logic signed [15:0] a_rd, b_rd, m_rd;
  logic [AAddrW-1:0] a_wa, a_ra;
  logic [BAddrW-1:0] b_wa, b_ra;
  logic [MAddrW-1:0] m_wa, m_ra;

  assign a_wa = {ld_row[AChW-1:0], ld_pos[PosW-1:0]};
  assign b_wa = {ld_row[BChW-1:0], ld_pos[PosW-1:0]};
  assign m_wa = {ld_row[FldW-1:0], ld_pos[PosW-1:0]};
  assign a_ra = {q_a[AChW-1:0], cmd.pos};
  assign b_ra = {q_b[BChW-1:0], cmd.pos};
  assign m_ra = {q_row[FldW-1:0], cmd.pos};

  mbp_ram #(.Width(16), .Depth(ADepth)) u_a (
    .clk(clk), .we(we_a), .waddr(a_wa), .wdata(ld_sample), .raddr(a_ra), .rdata(a_rd));
  mbp_ram #(.Width(16), .Depth(BDepth)) u_b (
    .clk(clk), .we(we_b), .waddr(b_wa), .wdata(ld_sample), .raddr(b_ra), .rdata(b_rd));
  mbp_ram #(.Width(16), .Depth(MDepth)) u_m (
    .clk(clk), .we(we_m), .waddr(m_wa), .wdata(ld_sample), .raddr(m_ra), .rdata(m_rd));

  // v1: RAM data valid, pa/pb computed at v2, av/bv at v3, prod at v4.
  logic v1, v2, v3, v4;
  logic signed [31:0] pa, pb;       // raw mask products
  logic signed [15:0] av, bv;       // masked, saturated
  logic               s2;
  logic signed [31:0] prod;
  logic               s3;

  // Floor shift then saturate; arithmetic shift is floor.
  function automatic logic [16:0] mask_sat(input logic signed [31:0] p);
    logic signed [23:0] q;
    q = 24'(p >>> 8);
    if (q > 24'sd32767) begin
      mask_sat = {1'b1, 16'h7FFF};
    end else if (q < -24'sd32768) begin
      mask_sat = {1'b1, 16'h8000};
    end else begin
      mask_sat = {1'b0, q[15:0]};
    end
  endfunction

  logic [16:0] ma, mb;
  assign ma = mask_sat(pa);
  assign mb = mask_sat(pb);

  logic signed [48:0] sum;
  assign sum = 49'(acc) + 49'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
    end else begin
      v1 <= cmd.feed; v2 <= v1; v3 <= v2; v4 <= v3;
    end
    pa <= a_rd * m_rd;
    pb <= b_rd * m_rd;
    av <= ma[15:0];
    bv <= mb[15:0];
    s2 <= ma[16] | mb[16];
    prod <= av * bv;
    s3 <= s2;
    if (cmd.clear) begin
      acc <= '0;
      sat <= 1'b0;
    end else if (v4) begin
      if (sum > 49'(AccMax)) begin
        acc <= AccMax; sat <= 1'b1;
      end else if (sum < 49'(AccMin)) begin
        acc <= AccMin; sat <= 1'b1;
      end else begin
        acc <= sum[47:0]; sat <= sat | s3;
      end
    end
  end

  assign stat.busy = v1 | v2 | v3 | v4;
endmodule
`default_nettype wire

// ----- rtl/mbp_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mbp_ctrl: query sequencer
// Steps the position counter through a query and waits for the pipeline.
// ----------------------------------------------------------------------------
module mbp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              go,
  input  wire logic [8:0]        npos,
  input  wire mbp_pkg::dp_stat_t stat,
  output mbp_pkg::dp_cmd_t       cmd,
  output logic                   done,
  output logic                   active
);
  import mbp_pkg::*;

  state_t state, state_next;
  logic [8:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd.clear  = 1'b0;
    cmd.feed   = 1'b0;
    cmd.pos    = cnt[PosW-1:0];
    done       = 1'b0;
    active     = 1'b1;
    unique case (state)
      S_IDLE: begin
        active = 1'b0;
        if (go) begin
          cmd.clear  = 1'b1;
          cnt_next   = '0;
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        cmd.feed  = 1'b1;
        cnt_next  = cnt + 9'd1;
        if (cnt + 9'd1 >= npos) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat.busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        done       = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire
